### design/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg: shared types and constants of the priority event dispatcher
// Field widths, status and register codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package ped_pkg;

	// item fields
	localparam int unsigned ACTION_W   = 1;
	localparam int unsigned TASK_IDX_W = 2;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned TDATA_W    = 40;  // task (2) + event (32), padded to bytes

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd4;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned TCOUNT_W   = 3;
	localparam int unsigned PRIO_W     = 8;
	localparam int unsigned PRIO_REGS  = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO0      = 3'd1;

	// controller to datapath commands
	typedef struct packed {
		logic latch;   // capture the accepted item
		logic exec;    // decide, update pointers, access the store
		logic load;    // move the result into the output register
	} cmd_t;

endpackage

### design/priority_event_dispatcher_top.sv
// ----------------------------------------------------------------------------
// priority_event_dispatcher_top: strict-priority multi-queue event dispatcher
// Per-task ring queues of events; dispatch pops from the lowest-priority-value
// non-empty active queue, lowest index on ties.
// ----------------------------------------------------------------------------
// Flow: the sequencer captures the accepted item, executes it (decision,
//   pointer update and the store's registered read), then loads the output
//   register; the load waits while the previous result is still untaken.
//   No new item is accepted until the result is loaded; the store has one read port.
// Reset (arst_n low, async): pointers, task_count and priorities go to zero,
//   output valid drops; store contents are undefined until written.
// ----------------------------------------------------------------------------
module priority_event_dispatcher_top
	import ped_pkg::*;
#(
	parameter int unsigned NUM_TASKS   = 4,   // 1..4
	parameter int unsigned QUEUE_DEPTH = 16,  // 2..256 slots, one kept free
	parameter int unsigned EVENT_WIDTH = 32   // 1..64 stored event bits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input item stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [1:0] task_index, [33:2] event_data
	input  logic [ACTION_W-1:0]   s_tuser,   // [0] action
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [1:0] served_task, [33:2] event_out
	output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t                  cmd;
	logic [TASK_IDX_W-1:0] served_task;
	logic [DATA_W-1:0]     event_out;

	// sequencer: owns both handshakes
	ped_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// queues, config and result registers
	ped_datapath #(
		.NUM_TASKS   (NUM_TASKS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.EVENT_WIDTH (EVENT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (s_tuser),
		.task_index  (s_tdata[TASK_IDX_W-1:0]),
		.event_data  (s_tdata[TASK_IDX_W +: DATA_W]),
		.status      (m_tuser),
		.served_task (served_task),
		.event_out   (event_out)
	);

	// pack result fields, pad bits are zero
	assign m_tdata = {{(TDATA_W - TASK_IDX_W - DATA_W){1'b0}}, event_out, served_task};

	// only one item in flight: no accept until the previous result is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in flight");

endmodule

### design/ped_ctrl.sv
// ----------------------------------------------------------------------------
// ped_ctrl: sequencing controller of the priority event dispatcher
// Three-state sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module ped_ctrl
	import ped_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd.latch = 1'b0;
		cmd.exec  = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	// an accepted item is executed in the very next cycle
	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.exec)
		else $error("accepted item not executed");

endmodule

### design/ped_datapath.sv
// ----------------------------------------------------------------------------
// ped_datapath: queues, pointers and priority select of the dispatcher
// Holds config registers, the ring pointers, the event store and result regs.
// ----------------------------------------------------------------------------
module ped_datapath
	import ped_pkg::*;
#(
	parameter int unsigned NUM_TASKS   = 4,
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned EVENT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ACTION_W-1:0]   action,
	input  logic [TASK_IDX_W-1:0] task_index,
	input  logic [DATA_W-1:0]     event_data,
	output logic [STATUS_W-1:0]   status,
	output logic [TASK_IDX_W-1:0] served_task,
	output logic [DATA_W-1:0]     event_out
);

	localparam int unsigned TW     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
	localparam int unsigned AW     = $clog2(NUM_TASKS * QUEUE_DEPTH);
	localparam int unsigned SLOTS  = NUM_TASKS * QUEUE_DEPTH;
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [TCOUNT_W-1:0] NT = TCOUNT_W'(NUM_TASKS);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	// config
	logic [TCOUNT_W-1:0] task_count_q;
	logic [PRIO_W-1:0]   prio_q [PRIO_REGS];
	logic [TCOUNT_W-1:0] eff_n;

	// item capture
	logic [ACTION_W-1:0]   action_q;
	logic [TASK_IDX_W-1:0] task_q;
	logic [DATA_W-1:0]     data_q;

	// ring pointers
	logic [PW-1:0] head_q [NUM_TASKS];
	logic [PW-1:0] tail_q [NUM_TASKS];

	// store
	logic [EVENT_WIDTH-1:0] mem [SLOTS];
	logic [EVENT_WIDTH-1:0] rd_q;

	// decision
	logic [TW-1:0]   task_sel;
	logic            bad_idx;
	logic            full;
	logic            enq_ok;
	logic            found;
	logic [TW-1:0]   best;
	logic [PRIO_W-1:0] win_prio;
	logic            disp_ok;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic [STATUS_W-1:0] status_d;

	// pending result
	logic [STATUS_W-1:0]   res_status_q;
	logic [TASK_IDX_W-1:0] res_task_q;
	logic                  res_evt_q;

	// output register
	logic [STATUS_W-1:0]   out_status_q;
	logic [TASK_IDX_W-1:0] out_task_q;
	logic [DATA_W-1:0]     out_event_q;

	assign eff_n    = (task_count_q > NT) ? NT : task_count_q;
	assign task_sel = task_q[TW-1:0];
	assign bad_idx  = (TCOUNT_W'(task_q) >= eff_n);
	assign full     = (ring_next(tail_q[task_sel]) == head_q[task_sel]);
	assign enq_ok   = (action_q == ACT_ENQUEUE) && !bad_idx && !full;

	always_comb begin
		found    = 1'b0;
		best     = '0;
		win_prio = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if ((TCOUNT_W'(i) < eff_n) && (head_q[i] != tail_q[i])
					&& (!found || (prio_q[i] < win_prio))) begin
				found    = 1'b1;
				best     = TW'(i);
				win_prio = prio_q[i];
			end
		end
	end

	assign disp_ok = (action_q == ACT_DISPATCH) && found;
	assign wr_addr = AW'(task_sel) * AW'(QUEUE_DEPTH) + AW'(tail_q[task_sel]);
	assign rd_addr = AW'(best) * AW'(QUEUE_DEPTH) + AW'(head_q[best]);

	always_comb begin
		if (action_q == ACT_DISPATCH) begin
			status_d = found ? ST_DISPATCHED : ST_IDLE;
		end else if (bad_idx) begin
			status_d = ST_BAD_INDEX;
		end else if (full) begin
			status_d = ST_DROPPED;
		end else begin
			status_d = ST_ENQUEUED;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			for (int i = 0; i < PRIO_REGS; i++) begin
				prio_q[i] <= '0;
			end
			for (int i = 0; i < NUM_TASKS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TASK_COUNT) begin
					task_count_q <= cfg_data[TCOUNT_W-1:0];
				end else if (cfg_index < CFG_PRIO0 + CFG_IDX_W'(PRIO_REGS)) begin
					prio_q[2'(cfg_index - CFG_PRIO0)] <= cfg_data[PRIO_W-1:0];
				end
			end
			if (cmd.exec && enq_ok) begin
				tail_q[task_sel] <= ring_next(tail_q[task_sel]);
			end
			if (cmd.exec && disp_ok) begin
				head_q[best] <= ring_next(head_q[best]);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action;
			task_q   <= task_index;
			data_q   <= event_data;
		end
		if (cmd.exec) begin
			res_status_q <= status_d;
			res_task_q   <= disp_ok ? TASK_IDX_W'(best) : '0;
			res_evt_q    <= disp_ok;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_task_q   <= res_task_q;
			out_event_q  <= res_evt_q ? DATA_W'(rd_q) : '0;
		end
	end

	// event store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			mem[wr_addr] <= EVENT_WIDTH'(data_q);
		end
		if (cmd.exec && disp_ok) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign status      = out_status_q;
	assign served_task = out_task_q;
	assign event_out   = out_event_q;

	// the served task is always an active one
	a_best_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && disp_ok) |-> (TCOUNT_W'(best) < eff_n))
		else $error("dispatch served an inactive task");

	// a successful enqueue leaves that queue non-empty
	a_enq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && enq_ok) |=> (head_q[task_sel] != tail_q[task_sel]))
		else $error("queue empty after enqueue");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for priority_event_dispatcher_top
// Streams enqueue and dispatch items through the block under random sender
// gaps and receiver stalls. A behavioral scheduler predicts every result.
// Checks cover status, served task and event word, across several register
// settings. Those settings include task counts above the task limit,
// shrinking counts and priority extremes.
// ----------------------------------------------------------------------------
module testbench;
	import ped_pkg::*;

	localparam int unsigned NTASKS = 4;
	localparam int unsigned QDEPTH = 16;
	localparam int unsigned EVW    = 32;
	localparam int unsigned PHASES = 12;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [TASK_IDX_W-1:0] dest_task;
		logic [DATA_W-1:0]     event_data;
	} sched_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [TASK_IDX_W-1:0] served_task;
		logic [DATA_W-1:0]     event_out;
	} sched_result_t;

	// DUT ports; every input starts at a known value
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata = '0;  // [1:0] task_index, [33:2] event_data
	logic [ACTION_W-1:0]   s_tuser = '0;  // [0] action
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;       // [1:0] served_task, [33:2] event_out
	logic [STATUS_W-1:0]   m_tuser;       // [2:0] status
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	priority_event_dispatcher_top #(
		.NUM_TASKS  (NTASKS),
		.QUEUE_DEPTH(QDEPTH),
		.EVENT_WIDTH(EVW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scheduler model: per-task rings, pointers, task count and priorities.
	// Updated on every accepted item and on every register write.
	// ------------------------------------------------------------------------
	logic [EVW-1:0]      ring_store [NTASKS][QDEPTH];
	int unsigned         ring_head [NTASKS];
	int unsigned         ring_tail [NTASKS];
	logic [TCOUNT_W-1:0] model_task_count;
	logic [PRIO_W-1:0]   model_prio [PRIO_REGS];

	sched_item_t   pending_items [$];   // items waiting for the driver
	sched_result_t expected_results [$];
	sched_item_t   cur_item;            // item currently on s_tdata/s_tuser
	bit            in_taken = 1'b0;     // item accepted at the last rising edge
	int unsigned   tx_gap = 0, tx_steady = 0;
	int unsigned   rx_gap = 0, rx_steady = 0;
	int unsigned   mismatch_count = 0;

	// counts above the task limit behave like the limit
	function automatic int unsigned active_tasks();
		return (model_task_count > NTASKS) ? NTASKS : int'(model_task_count);
	endfunction

	function automatic sched_result_t schedule_step(input sched_item_t it);
		sched_result_t res;
		int unsigned   n, nxt, best, win_prio;
		bit            found;
		res = '0;
		n = active_tasks();
		if (it.action == ACT_ENQUEUE) begin
			if (it.dest_task >= n) begin
				res.status = ST_BAD_INDEX;
			end else begin
				nxt = (ring_tail[it.dest_task] + 1) % QDEPTH;
				if (nxt == ring_head[it.dest_task]) begin
					res.status = ST_DROPPED;  // one slot always stays free
				end else begin
					ring_store[it.dest_task][ring_tail[it.dest_task]] = it.event_data;
					ring_tail[it.dest_task] = nxt;
					res.status = ST_ENQUEUED;
				end
			end
		end else begin
			found = 1'b0;
			best = 0;
			win_prio = 0;
			// strict less-than keeps the lowest index on equal priorities
			for (int i = 0; i < n; i++) begin
				if (ring_head[i] != ring_tail[i] && (!found || model_prio[i] < win_prio)) begin
					found = 1'b1;
					best = i;
					win_prio = model_prio[i];
				end
			end
			if (!found) begin
				res.status = ST_IDLE;
			end else begin
				res.status = ST_DISPATCHED;
				res.served_task = best[TASK_IDX_W-1:0];
				res.event_out = ring_store[best][ring_head[best]];
				ring_head[best] = (ring_head[best] + 1) % QDEPTH;
			end
		end
		return res;
	endfunction

	function automatic sched_item_t mk_item(logic [ACTION_W-1:0] act,
			logic [TASK_IDX_W-1:0] idx, logic [DATA_W-1:0] ev);
		sched_item_t it;
		it.action = act;
		it.dest_task = idx;
		it.event_data = ev;
		return it;
	endfunction

	// dispatch ignores index and event, so those carry noise
	function automatic sched_item_t mk_dispatch();
		return mk_item(ACT_DISPATCH, TASK_IDX_W'($urandom_range(0, 3)), $urandom);
	endfunction

	// mostly short gaps, a few long ones, and now and then a gap-free stretch
	function automatic int unsigned pick_gap(inout int unsigned steady_left);
		int unsigned r;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			steady_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: acceptance is noted at the rising edge (predict there), the next
	// item or gap is driven at the falling edge. s_tvalid gets one NBA per step.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : note_accept
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(schedule_step(cur_item));
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin : drive_items
		logic next_valid;
		next_valid = s_tvalid && !in_taken;
		in_taken = 1'b0;
		if (arst_n && !next_valid) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				s_tdata <= {{(TDATA_W - TASK_IDX_W - DATA_W){1'b0}},
					cur_item.event_data, cur_item.dest_task};
				s_tuser <= cur_item.action;
				next_valid = 1'b1;
				tx_gap = pick_gap(tx_steady);
			end
		end
		s_tvalid <= next_valid;
	end

	// receiver: random stalls of random length
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 2) == 0) rx_gap = pick_gap(rx_steady);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: each accepted result against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		sched_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.served_task = m_tdata[TASK_IDX_W-1:0];
			got.event_out = m_tdata[TASK_IDX_W +: DATA_W];
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d task=%0d ev=%h",
					got.status, got.served_task, got.event_out));
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got.status, want.status));
				if (got.served_task !== want.served_task)
					report_mismatch($sformatf("served_task got %0d want %0d",
						got.served_task, want.served_task));
				if (got.event_out !== want.event_out)
					report_mismatch($sformatf("event_out got %h want %h",
						got.event_out, want.event_out));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus sequencing
	// ------------------------------------------------------------------------

	// waits until the sender is empty and every result is back
	task automatic wait_quiet();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// cfg_we stays high across a batch; close_writes lowers it once
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TASK_COUNT) model_task_count = val[TCOUNT_W-1:0];
		else model_prio[idx - CFG_PRIO0] = val[PRIO_W-1:0];
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [PRIO_W-1:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return PRIO_W'($urandom_range(0, 2));  // likely ties
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	// bursts of enqueues to one task (reach full), bursts of dispatches
	// (reach idle), and a share of fully random items
	task automatic queue_random_phase(input int unsigned count);
		int unsigned n, k, kind, len, tgt;
		n = active_tasks();
		k = 0;
		while (k < count) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 24);
			tgt = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
				: $urandom_range(0, 3);
			for (int j = 0; j < len && k < count; j++, k++) begin
				if (kind < 4)
					pending_items.push_back(mk_item(ACT_ENQUEUE, TASK_IDX_W'(tgt), $urandom));
				else if (kind < 7)
					pending_items.push_back(mk_dispatch());
				else if ($urandom_range(0, 1) == 0)
					pending_items.push_back(mk_item(ACT_ENQUEUE,
						TASK_IDX_W'($urandom_range(0, 3)), $urandom));
				else
					pending_items.push_back(mk_dispatch());
			end
		end
	endtask

	initial begin : stimulus
		int unsigned tc_plan [PHASES];
		tc_plan = '{4, 4, 1, 7, 0, 2, 3, 5, 4, 6, 4, 3};
		for (int i = 0; i < NTASKS; i++) begin
			ring_head[i] = 0;
			ring_tail[i] = 0;
		end
		model_task_count = '0;
		for (int i = 0; i < PRIO_REGS; i++) model_prio[i] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: no task exists, so enqueue is a bad index, dispatch idle
		pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd0, 32'h1234_5678));
		pending_items.push_back(mk_dispatch());
		wait_quiet();

		// priority 255 on tasks 0 and 3, 0 on tasks 1 and 2
		write_reg(CFG_TASK_COUNT, 8'd4);
		write_reg(CFG_PRIO0 + 3'd0, 8'd255);
		write_reg(CFG_PRIO0 + 3'd1, 8'd0);
		write_reg(CFG_PRIO0 + 3'd2, 8'd0);
		write_reg(CFG_PRIO0 + 3'd3, 8'd255);
		close_writes();
		pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd0, 32'hFFFF_FFFF));
		pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd3, 32'h0000_0000));
		pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd1, 32'h5A5A_5A5A));
		pending_items.push_back(mk_dispatch());  // task 1, lowest priority value
		pending_items.push_back(mk_dispatch());  // 255 tie: task 0 before task 3
		// fill task 2 to the brim; the last one is dropped
		for (int i = 0; i < QDEPTH; i++)
			pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd2, $urandom));
		pending_items.push_back(mk_dispatch());  // task 2 beats task 3
		wait_quiet();

		// shrink: task 2 keeps its events but is out of reach
		write_reg(CFG_TASK_COUNT, 8'd2);
		close_writes();
		pending_items.push_back(mk_item(ACT_ENQUEUE, 2'd2, $urandom));
		pending_items.push_back(mk_dispatch());  // tasks 0 and 1 empty: idle
		wait_quiet();
		// count above the limit acts as all tasks
		write_reg(CFG_TASK_COUNT, 8'd7);
		close_writes();
		pending_items.push_back(mk_dispatch());
		wait_quiet();

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_TASK_COUNT, CFG_DATA_W'(tc_plan[p]));
			for (int i = 0; i < PRIO_REGS; i++) begin
				if (p == 0) write_reg(CFG_PRIO0 + CFG_IDX_W'(i), 8'd0);
				else if (p == 1) write_reg(CFG_PRIO0 + CFG_IDX_W'(i), 8'd255);
				else write_reg(CFG_PRIO0 + CFG_IDX_W'(i), pick_prio());
			end
			close_writes();
			queue_random_phase(tc_plan[p] == 0 ? 40 : 155);
			wait_quiet();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("priority_event_dispatcher_top test passed");
		end else begin
			$display("priority_event_dispatcher_top test failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("priority_event_dispatcher_top test failed");
		$finish;
	end

endmodule

### sim.f
design/ped_pkg.sv
design/ped_ctrl.sv
design/ped_datapath.sv
design/priority_event_dispatcher_top.sv
tb/testbench.sv
